// File: design/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the letter table of the Morse letter keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

    localparam int unsigned UNIT_W   = 24;
    localparam int unsigned DUR_W    = 26;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned SYM_W    = 8;

    localparam logic [UNIT_W-1:0]  UNIT_RESET = 24'd200000;
    localparam logic [LEVEL_W-1:0] LEVEL_UP   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_DOWN = 2'd3;
    localparam logic [SYM_W-1:0]   CHAR_A     = 8'h41;
    localparam logic [SYM_W-1:0]   CHAR_Z     = 8'h5A;

    // Element i of a letter is a dash when dash[i] is set.
    typedef struct packed {
        logic [3:0] dash;
        logic [2:0] count;
    } t_code;

    function automatic t_code letter_code(input logic [4:0] idx);
        t_code c;
        case (idx)
            5'd0:    c = 7'b0010_010; // A
            5'd1:    c = 7'b0001_100; // B
            5'd2:    c = 7'b0101_100; // C
            5'd3:    c = 7'b0001_011; // D
            5'd4:    c = 7'b0000_001; // E
            5'd5:    c = 7'b0100_100; // F
            5'd6:    c = 7'b0011_011; // G
            5'd7:    c = 7'b0000_100; // H
            5'd8:    c = 7'b0000_010; // I
            5'd9:    c = 7'b1110_100; // J
            5'd10:   c = 7'b0101_011; // K
            5'd11:   c = 7'b0010_100; // L
            5'd12:   c = 7'b0011_010; // M
            5'd13:   c = 7'b0001_010; // N
            5'd14:   c = 7'b0111_011; // O
            5'd15:   c = 7'b0110_100; // P
            5'd16:   c = 7'b1011_100; // Q
            5'd17:   c = 7'b0010_011; // R
            5'd18:   c = 7'b0000_011; // S
            5'd19:   c = 7'b0001_001; // T
            5'd20:   c = 7'b0100_011; // U
            5'd21:   c = 7'b1000_100; // V
            5'd22:   c = 7'b0110_011; // W
            5'd23:   c = 7'b1001_100; // X
            5'd24:   c = 7'b1101_100; // Y
            5'd25:   c = 7'b0011_100; // Z
            default: c = 7'b0000_000;
        endcase
        return c;
    endfunction

endpackage

// File: design/morse_letter_keyer_unit.sv
// ----------------------------------------------------------------------------
// morse_letter_keyer_unit
// Keys one message character per word as a run of pin segments (level and
// hold time) in International Morse code.
// ----------------------------------------------------------------------------
// On acceptance the character is registered in the sequencer state; its first
// segment then goes into the output register when the output side can take it,
// and then one segment per cycle while the output side takes them.
// The segment sequencer sets how many segments a character takes; the input
// is ready only while the sequencer is idle.
// Reset: synchronous, active low; sequencer idle, no message in progress,
// unit length back to mlk_pkg::UNIT_RESET.
module morse_letter_keyer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mlk_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_final_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mlk_pkg::LEVEL_W-1:0]   o_pin_level,
    output logic [mlk_pkg::DUR_W-1:0]     o_duration,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [mlk_pkg::UNIT_W-1:0]    i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GAP   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DOWN  = 3'd3;
    localparam logic [2:0] ST_UP    = 3'd4;
    localparam logic [2:0] ST_CLOSE = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic                         r_started;
    logic [mlk_pkg::UNIT_W-1:0]   r_unit;
    logic [mlk_pkg::DUR_W-1:0]    r_dot_dur, r_dash_dur;
    mlk_pkg::t_code               r_code;
    logic                         r_final;
    logic [1:0]                   r_elem, n_elem;

    logic                         r_out_valid;
    logic [mlk_pkg::LEVEL_W-1:0]  r_out_level, n_out_level;
    logic [mlk_pkg::DUR_W-1:0]    r_out_dur, n_out_dur;
    logic                         r_out_last, n_out_last;

    logic                         accept, emit, is_letter, elem_done;
    logic [mlk_pkg::SYM_W-1:0]    sym_off;
    logic [mlk_pkg::DUR_W-1:0]    unit_eff;
    mlk_pkg::t_code               lookup;

    assign o_ready     = (r_state == ST_IDLE);
    assign accept      = i_valid && o_ready;
    assign emit        = (r_state != ST_IDLE) && (!r_out_valid || i_ready);

    assign is_letter   = (i_symbol inside {[mlk_pkg::CHAR_A:mlk_pkg::CHAR_Z]});
    assign sym_off     = i_symbol - mlk_pkg::CHAR_A;
    assign lookup      = is_letter ? mlk_pkg::letter_code(sym_off[4:0]) : '0;

    // a zero unit length is keyed as the smallest nonzero unit length
    assign unit_eff    = (r_unit == '0) ? mlk_pkg::DUR_W'(1) : mlk_pkg::DUR_W'(r_unit);
    assign elem_done   = (({1'b0, r_elem} + 3'd1) == r_code.count);

    always_comb begin
        n_state     = r_state;
        n_elem      = r_elem;
        n_out_level = mlk_pkg::LEVEL_UP;
        n_out_dur   = r_dot_dur;
        n_out_last  = 1'b0;
        case (r_state)
            ST_GAP: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_elem = 2'd0;
                if (r_code.count != 3'd0) begin
                    n_state = ST_DOWN;
                end else if (r_final) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_state    = ST_IDLE;
                    n_out_last = 1'b1;
                end
            end
            ST_DOWN: begin
                n_out_level = mlk_pkg::LEVEL_DOWN;
                n_out_dur   = r_code.dash[r_elem] ? r_dash_dur : r_dot_dur;
                n_state     = ST_UP;
            end
            ST_UP: begin
                if (!elem_done) begin
                    n_state = ST_DOWN;
                    n_elem  = r_elem + 2'd1;
                end else if (r_final) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_state    = ST_IDLE;
                    n_out_last = 1'b1;
                end
            end
            ST_CLOSE: begin
                n_state    = ST_IDLE;
                n_out_last = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_unit      <= mlk_pkg::UNIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_unit <= i_cfg_data;
            end
            if (accept) begin
                r_state   <= r_started ? ST_START : ST_GAP;
                r_started <= !i_final_req;
            end else if (emit) begin
                r_state <= n_state;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch the character and both hold times; the dash time is unit plus twice unit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code     <= lookup;
            r_final    <= i_final_req;
            r_elem     <= 2'd0;
            r_dot_dur  <= unit_eff;
            r_dash_dur <= unit_eff + {unit_eff[mlk_pkg::DUR_W-2:0], 1'b0};
        end else if (emit) begin
            r_elem <= n_elem;
        end
        if (emit) begin
            r_out_level <= n_out_level;
            r_out_dur   <= n_out_dur;
            r_out_last  <= n_out_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pin_level = r_out_level;
    assign o_duration  = r_out_dur;
    assign o_last      = r_out_last;

endmodule
